### rtl/core/mlbc_pkg.sv
// Shared types and constants for the multi-LED blink controller.
// Holds operation codes, transaction structs and parameter defaults; no dependencies.
`timescale 1ns / 1ps

package mlbc_pkg;

   // parameter defaults
   localparam int DEF_NUM_LEDS    = 8;
   localparam int DEF_PERIOD_BITS = 16;
   localparam int DEF_TIME_BITS   = 32;

   // fixed field widths
   localparam int OP_W       = 3;
   localparam int MASK_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int RUN_TIME_W = 32;
   localparam int PCT_W      = 8;
   localparam int PERIOD_W   = 16;
   localparam int LEVELS_W   = 8;
   localparam int CYCLES_W   = 32;
   localparam int DUTY_W     = 8;

   // derived defaults for lower modules
   localparam int DEF_IDX_W      = 3;
   localparam int DEF_DIVIDEND_W = DEF_PERIOD_BITS + PCT_W;
   localparam int DEF_ENTRY_W    = 4 + CYCLES_W + DUTY_W + DEF_PERIOD_BITS + DEF_TIME_BITS;

   // operation codes
   localparam logic [OP_W-1:0] OP_ON          = 3'd0;
   localparam logic [OP_W-1:0] OP_OFF         = 3'd1;
   localparam logic [OP_W-1:0] OP_TOGGLE      = 3'd2;
   localparam logic [OP_W-1:0] OP_BLINK_COUNT = 3'd3;
   localparam logic [OP_W-1:0] OP_BLINK_TIME  = 3'd4;
   localparam logic [OP_W-1:0] OP_TOGGLE_RUN  = 3'd5;
   localparam logic [OP_W-1:0] OP_TICK        = 3'd6;

   // percent constants
   localparam logic [PCT_W-1:0] PCT_FULL = 8'd100;
   localparam logic [PCT_W-1:0] PCT_HALF = 8'd50;

   typedef struct packed {
      logic [OP_W-1:0]       operation;
      logic [MASK_W-1:0]     led_mask;
      logic [COUNT_W-1:0]    cycle_count;
      logic [RUN_TIME_W-1:0] run_time;
      logic [PCT_W-1:0]      on_percent;
      logic [PERIOD_W-1:0]   blink_period;
   } req_type;

   typedef struct packed {
      logic [LEVELS_W-1:0] led_levels;
      logic [LEVELS_W-1:0] blinking;
   } rsp_type;

   typedef struct packed {
      logic    idle;
      logic    done;
      rsp_type result;
   } seq_status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/core/mlbc_mem.sv
// Per-LED state memory: one synchronous write port, one read port with registered data.
// Entries that were never written since reset read as zero. Uses mlbc_pkg.
`timescale 1ns / 1ps

module mlbc_mem #(
   parameter int DEPTH  = mlbc_pkg::DEF_NUM_LEDS,
   parameter int WIDTH  = mlbc_pkg::DEF_ENTRY_W,
   parameter int ADDR_W = mlbc_pkg::DEF_IDX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic             rvalid_ff, rvalid_in;

   // storage array and read data register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   // written flags, cleared at once by reset
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rvalid_in = rd_en ? valid_ff[rd_addr] : rvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

   // the sequencer never reads an entry in the cycle it writes it
   assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && (rd_addr == wr_addr)))
      else $error("mlbc_mem: read and write of the same entry in one cycle");

endmodule

### rtl/core/mlbc_div100.sv
// Iterative divide-by-100 unit, four quotient bits per cycle.
// Used for phase lengths pct*period/100. Uses mlbc_pkg.
`timescale 1ns / 1ps

module mlbc_div100 #(
   parameter int DIVIDEND_W = mlbc_pkg::DEF_DIVIDEND_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_W-1:0]         dividend,
   output mlbc_pkg::div_status_type      status,
   output logic [DIVIDEND_W-1:0]         quotient
);

   localparam int STEPS = (DIVIDEND_W + 3) / 4;
   localparam int PAD_W = 4 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [6:0]       rem_ff, rem_in;
   logic [PAD_W-1:0] shr_ff, shr_in;
   logic [PAD_W-1:0] quo_ff, quo_in;

   logic [6:0]       rem_v;
   logic [7:0]       r8;
   logic [PAD_W-1:0] shr_v;
   logic [PAD_W-1:0] quo_v;

   // four restoring steps on the narrow remainder
   always_comb begin
      rem_v = rem_ff;
      shr_v = shr_ff;
      quo_v = quo_ff;
      r8    = '0;
      for (int k = 0; k < 4; k++) begin
         r8    = {rem_v, shr_v[PAD_W-1]};
         shr_v = shr_v << 1;
         if (r8 >= mlbc_pkg::PCT_FULL) begin
            r8    = r8 - mlbc_pkg::PCT_FULL;
            quo_v = {quo_v[PAD_W-2:0], 1'b1};
         end else begin
            quo_v = {quo_v[PAD_W-2:0], 1'b0};
         end
         rem_v = r8[6:0];
      end
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shr_in  = shr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         rem_in  = '0;
         shr_in  = PAD_W'(dividend);
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_v;
         shr_in = shr_v;
         quo_in = quo_v;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shr_ff <= shr_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff[DIVIDEND_W-1:0];

   // a new division only starts once the last one is finished
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("mlbc_div100: start while busy");

endmodule

### rtl/core/mlbc_seq.sv
// Sequencer of the blink controller: walks the per-LED entries with read-modify-write.
// Holds LED levels, saved levels and the ms clock. Uses mlbc_pkg, mlbc_mem, mlbc_div100.
`timescale 1ns / 1ps

module mlbc_seq #(
   parameter int NUM_LEDS    = mlbc_pkg::DEF_NUM_LEDS,
   parameter int PERIOD_BITS = mlbc_pkg::DEF_PERIOD_BITS,
   parameter int TIME_BITS   = mlbc_pkg::DEF_TIME_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  mlbc_pkg::req_type        req_data,
   input  logic                     out_ready,
   output mlbc_pkg::seq_status_type status
);

   localparam int IDX_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int CL_W     = mlbc_pkg::CYCLES_W;
   localparam int DUTY_W   = mlbc_pkg::DUTY_W;
   localparam int PCT_W    = mlbc_pkg::PCT_W;
   localparam int MASK_W   = mlbc_pkg::MASK_W;
   localparam int COUNT_W  = mlbc_pkg::COUNT_W;
   localparam int LEVELS_W = mlbc_pkg::LEVELS_W;
   localparam int PROD_W   = PERIOD_BITS + PCT_W;
   localparam int PASS_W   = ((TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS) + 1;
   localparam int CMP_W    = (PASS_W > CL_W) ? PASS_W : CL_W;

   typedef struct packed {
      logic                   on;
      logic                   blink;
      logic                   endless;
      logic                   by_time;
      logic [CL_W-1:0]        cycles_left;
      logic [DUTY_W-1:0]      duty;
      logic [PERIOD_BITS-1:0] cycle_len;
      logic [TIME_BITS-1:0]   next_change;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_EVAL = 6'b000100,
      S_UPD  = 6'b001000,
      S_DIV  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      K_NONE,
      K_SET,
      K_BLINK,
      K_TRUN,
      K_TICK
   } kind_type;

   state_type                  state_ff, state_in;
   kind_type                   kind_ff, kind_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [mlbc_pkg::OP_W-1:0]  op_ff, op_in;
   logic [NUM_LEDS-1:0]        tgt_ff, tgt_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [CL_W-1:0]            dur_ff, dur_in;
   logic [PCT_W-1:0]           pct_ff, pct_in;
   logic [PERIOD_BITS-1:0]     period_ff, period_in;
   logic [NUM_LEDS-1:0]        level_ff, level_in;
   logic [NUM_LEDS-1:0]        saved_ff, saved_in;
   logic [NUM_LEDS-1:0]        act_ff, act_in;
   logic [TIME_BITS-1:0]       now_ff, now_in;
   entry_type                  work_ff, work_in;
   logic                       due_ff, due_in;
   logic [PASS_W-1:0]          pass_ff, pass_in;

   // memory and divider hookup
   logic                       mem_rd_en, mem_wr_en;
   logic [ENTRY_W-1:0]         mem_rd_data, mem_wr_data;
   entry_type                  rd_ent;
   logic                       div_start;
   logic [PROD_W-1:0]          div_prod;
   logic [PROD_W-1:0]          div_quot;
   mlbc_pkg::div_status_type   div_st;

   // transaction decode
   logic [NUM_LEDS+MASK_W-1:0] mask_wide;
   logic [NUM_LEDS-1:0]        tgt_new;
   logic                       mask_ok;
   logic [PERIOD_BITS-1:0]     period_new;
   kind_type                   kind_new;
   logic [NUM_LEDS-1:0]        level_start;

   // per-entry update
   entry_type                  upd_ent;
   entry_type                  div_ent;
   logic                       upd_lvl, upd_sv, upd_div;
   logic                       cur_lvl, cur_sv, cur_tgt;
   logic [PCT_W-1:0]           tick_pct;
   logic [CL_W-1:0]            blink_lim;
   logic [COUNT_W:0]           half_sum;
   logic [CL_W-1:0]            trun_cl;
   logic [TIME_BITS-1:0]       eval_diff;
   logic                       last_led;
   logic [NUM_LEDS+LEVELS_W-1:0] level_wide, act_wide;

   mlbc_mem #(
      .DEPTH  (NUM_LEDS),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (idx_ff),
      .wr_data (mem_wr_data)
   );

   mlbc_div100 #(
      .DIVIDEND_W (PROD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_prod),
      .status   (div_st),
      .quotient (div_quot)
   );

   assign rd_ent = entry_type'(mem_rd_data);

   // decode of an incoming transaction, whole-mask drives included
   always_comb begin
      mask_wide   = {{NUM_LEDS{1'b0}}, req_data.led_mask};
      tgt_new     = mask_wide[NUM_LEDS-1:0];
      mask_ok     = (mask_wide[NUM_LEDS +: MASK_W] == '0);
      period_new  = PERIOD_BITS'(req_data.blink_period);
      kind_new    = K_NONE;
      level_start = level_ff;
      case (req_data.operation) inside
         mlbc_pkg::OP_ON, mlbc_pkg::OP_OFF, mlbc_pkg::OP_TOGGLE: begin
            if (mask_ok) begin
               kind_new = K_SET;
            end
         end
         mlbc_pkg::OP_BLINK_COUNT, mlbc_pkg::OP_BLINK_TIME: begin
            if (mask_ok) begin
               if ((req_data.led_mask == '0) || (req_data.on_percent == '0) ||
                   (period_new == '0)) begin
                  level_start = level_ff & ~tgt_new;
               end else if (req_data.on_percent >= mlbc_pkg::PCT_FULL) begin
                  level_start = level_ff | tgt_new;
               end else begin
                  kind_new = K_BLINK;
               end
            end
         end
         mlbc_pkg::OP_TOGGLE_RUN: begin
            if (mask_ok) begin
               if ((req_data.led_mask == '0) || (period_new == '0)) begin
                  level_start = level_ff | tgt_new;
               end else begin
                  kind_new = K_TRUN;
               end
            end
         end
         mlbc_pkg::OP_TICK: begin
            kind_new = K_TICK;
         end
         default: begin
            kind_new = K_NONE;
         end
      endcase
   end

   // update of the entry held in the work register
   always_comb begin
      cur_lvl   = level_ff[idx_ff];
      cur_sv    = saved_ff[idx_ff];
      cur_tgt   = tgt_ff[idx_ff];
      upd_ent   = work_ff;
      upd_lvl   = cur_lvl;
      upd_sv    = cur_sv;
      upd_div   = 1'b0;
      tick_pct  = '0;
      blink_lim = (op_ff == mlbc_pkg::OP_BLINK_TIME) ? dur_ff : CL_W'(count_ff);
      half_sum  = (COUNT_W + 1)'(count_ff) + (COUNT_W + 1)'(1);
      trun_cl   = CL_W'(half_sum >> 1) - CL_W'(cur_lvl & count_ff[0]);
      case (kind_ff)
         K_SET: begin
            if (cur_tgt) begin
               if (op_ff == mlbc_pkg::OP_TOGGLE) begin
                  upd_ent.on = ~work_ff.on;
               end else begin
                  upd_ent.on      = (op_ff == mlbc_pkg::OP_ON);
                  upd_ent.blink   = 1'b0;
                  upd_ent.endless = 1'b0;
               end
               upd_lvl = upd_ent.on | upd_ent.blink | upd_ent.endless;
            end
         end
         K_BLINK: begin
            if (cur_tgt) begin
               if (!work_ff.blink) begin
                  upd_sv = cur_sv | cur_lvl;
               end
               upd_ent.on          = 1'b0;
               upd_ent.blink       = 1'b1;
               upd_ent.endless     = (blink_lim == '0);
               upd_ent.by_time     = (op_ff == mlbc_pkg::OP_BLINK_TIME);
               upd_ent.cycles_left = blink_lim;
               upd_ent.duty        = pct_ff;
               upd_ent.cycle_len   = period_ff;
               upd_ent.next_change = now_ff;
            end
         end
         K_TRUN: begin
            if (cur_tgt) begin
               if (!work_ff.blink && (cur_lvl != count_ff[0])) begin
                  upd_sv = 1'b1;
               end
               upd_ent.on          = cur_lvl;
               upd_ent.blink       = 1'b1;
               upd_ent.endless     = (count_ff == '0);
               upd_ent.by_time     = 1'b0;
               upd_ent.cycles_left = trun_cl;
               upd_ent.duty        = mlbc_pkg::PCT_HALF;
               upd_ent.cycle_len   = period_ff;
               upd_ent.next_change = now_ff;
               // a lit led with cycles left starts in its off half
               if (cur_lvl && (trun_cl != '0)) begin
                  upd_ent.on          = 1'b0;
                  upd_lvl             = 1'b0;
                  upd_ent.next_change = now_ff + TIME_BITS'(period_ff >> 1);
               end
            end
         end
         K_TICK: begin
            if (work_ff.blink && due_ff) begin
               if (work_ff.on) begin
                  tick_pct   = (work_ff.duty <= mlbc_pkg::PCT_FULL) ?
                               (mlbc_pkg::PCT_FULL - work_ff.duty) : '0;
                  upd_ent.on = 1'b0;
                  upd_lvl    = 1'b0;
                  if (!work_ff.endless) begin
                     if (!work_ff.by_time) begin
                        if (work_ff.cycles_left <= CL_W'(1)) begin
                           upd_ent.blink = 1'b0;
                        end
                        if (work_ff.cycles_left != '0) begin
                           upd_ent.cycles_left = work_ff.cycles_left - CL_W'(1);
                        end
                     end else if (CMP_W'(work_ff.cycles_left) > CMP_W'(pass_ff)) begin
                        upd_ent.cycles_left = work_ff.cycles_left - CL_W'(pass_ff);
                     end else begin
                        upd_ent.cycles_left = '0;
                        upd_ent.blink       = 1'b0;
                     end
                  end
               end else begin
                  tick_pct   = work_ff.duty;
                  upd_ent.on = 1'b1;
                  upd_lvl    = 1'b1;
               end
               if (upd_ent.blink) begin
                  upd_div = 1'b1;
               end else begin
                  // run over: back to the saved level
                  upd_ent.on      = cur_sv;
                  upd_ent.endless = 1'b0;
                  upd_lvl         = cur_sv;
                  upd_sv          = 1'b0;
               end
            end
         end
         default: begin
            upd_ent = work_ff;
         end
      endcase
   end

   assign div_prod  = PROD_W'(tick_pct) * PROD_W'(work_ff.cycle_len);
   assign eval_diff = now_ff - rd_ent.next_change;
   assign last_led  = (idx_ff == IDX_W'(NUM_LEDS - 1));

   always_comb begin
      div_ent             = work_ff;
      div_ent.next_change = now_ff + TIME_BITS'(div_quot);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      tgt_in      = tgt_ff;
      count_in    = count_ff;
      dur_in      = dur_ff;
      pct_in      = pct_ff;
      period_in   = period_ff;
      level_in    = level_ff;
      saved_in    = saved_ff;
      act_in      = act_ff;
      now_in      = now_ff;
      work_in     = work_ff;
      due_in      = due_ff;
      pass_in     = pass_ff;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_data = upd_ent;
      div_start   = 1'b0;
      status.done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_data.operation;
               tgt_in    = tgt_new;
               count_in  = req_data.cycle_count;
               dur_in    = CL_W'(req_data.run_time);
               pct_in    = req_data.on_percent;
               period_in = period_new;
               kind_in   = kind_new;
               level_in  = level_start;
               idx_in    = '0;
               if (kind_new == K_TICK) begin
                  now_in = now_ff + TIME_BITS'(1);
               end
               state_in = (kind_new == K_NONE) ? S_DONE : S_READ;
            end
         end
         S_READ: begin
            mem_rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            work_in  = rd_ent;
            due_in   = (now_ff >= rd_ent.next_change);
            pass_in  = PASS_W'(eval_diff) + PASS_W'(rd_ent.cycle_len);
            state_in = S_UPD;
         end
         S_UPD: begin
            level_in[idx_ff] = upd_lvl;
            saved_in[idx_ff] = upd_sv;
            act_in[idx_ff]   = upd_ent.blink;
            if (upd_div) begin
               work_in   = upd_ent;
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               mem_wr_en = 1'b1;
               if (last_led) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_DIV: begin
            mem_wr_data = div_ent;
            if (div_st.done) begin
               mem_wr_en = 1'b1;
               if (last_led) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            if (out_ready) begin
               status.done = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= K_NONE;
         idx_ff   <= '0;
         level_ff <= '0;
         saved_ff <= '0;
         act_ff   <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         level_ff <= level_in;
         saved_ff <= saved_in;
         act_ff   <= act_in;
         now_ff   <= now_in;
      end
   end

   // transaction and work payload
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      tgt_ff    <= tgt_in;
      count_ff  <= count_in;
      dur_ff    <= dur_in;
      pct_ff    <= pct_in;
      period_ff <= period_in;
      work_ff   <= work_in;
      due_ff    <= due_in;
      pass_ff   <= pass_in;
   end

   // result view, low eight leds
   assign level_wide = {{LEVELS_W{1'b0}}, level_ff};
   assign act_wide   = {{LEVELS_W{1'b0}}, act_ff};
   assign status.idle              = (state_ff == S_IDLE);
   assign status.result.led_levels = level_wide[LEVELS_W-1:0];
   assign status.result.blinking   = act_wide[LEVELS_W-1:0];

   // a transaction is only taken while idle
   assert property (@(posedge clock) disable iff (reset) start |-> (state_ff == S_IDLE))
      else $error("mlbc_seq: transaction started while busy");

   // a result is only handed over when the output side has room
   assert property (@(posedge clock) disable iff (reset) status.done |-> out_ready)
      else $error("mlbc_seq: result handed over without room");

   // while waiting on the divider it must be working or just finished
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_st.busy || div_st.done))
      else $error("mlbc_seq: waiting on an idle divider");

   // the sweep index stays inside the led bank
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (idx_ff <= IDX_W'(NUM_LEDS - 1)))
      else $error("mlbc_seq: led index out of range");

endmodule

### rtl/core/multi_led_blink_controller_top.sv
// Multi-LED blink controller top level: handshake and registered result stage.
// Each transaction sweeps all LEDs with one memory read-modify-write per LED,
// plus a run of the divide-by-100 unit for each LED whose phase changes on a tick;
// transactions with nothing to update skip the sweep.
// Throughput: one transaction at a time; the next is taken while the result waits.
// Reset is synchronous and clears all LED entries at once; no clearing pass.
`timescale 1ns / 1ps

module multi_led_blink_controller_top #(
   parameter int NUM_LEDS    = mlbc_pkg::DEF_NUM_LEDS,
   parameter int PERIOD_BITS = mlbc_pkg::DEF_PERIOD_BITS,
   parameter int TIME_BITS   = mlbc_pkg::DEF_TIME_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mlbc_pkg::rsp_type rsp_data
);

   mlbc_pkg::seq_status_type seq_st;
   logic                     start;
   logic                     out_ready;
   logic                     rsp_valid_ff, rsp_valid_in;
   mlbc_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   // input side accepts whenever the sequencer is idle
   assign req_stall = ~seq_st.idle;
   assign start     = req_valid & ~req_stall;
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;

   mlbc_seq #(
      .NUM_LEDS    (NUM_LEDS),
      .PERIOD_BITS (PERIOD_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .out_ready (out_ready),
      .status    (seq_st)
   );

   // result register
   always_comb begin
      rsp_valid_in = seq_st.done | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = seq_st.done ? seq_st.result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### dv/multi_led_blink_controller_tb.sv
// Self-checking testbench for multi_led_blink_controller_top: directed and random
// command/tick transactions, each result checked against an in-line LED bank predictor.
// Depends on mlbc_pkg and the top level RTL only.
`timescale 1ns / 1ps

module testbench;
   import mlbc_pkg::*;

   localparam int NUM_LEDS = DEF_NUM_LEDS;

   // operation code with no package name, must be a no-op
   localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;

   // per-led phase flags
   localparam logic [3:0] FLAG_LIT     = 4'b0001;
   localparam logic [3:0] FLAG_RUN     = 4'b0010;
   localparam logic [3:0] FLAG_FOREVER = 4'b0100;

   localparam int IDLE_PCT       = 26;
   localparam int RANDOM_ITEMS   = 1425;
   localparam int DRAIN_EVERY    = 350;
   localparam int TAIL_CYCLES    = 100;
   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // no random idling on either side while set
   logic    calm      = 1'b0;

   multi_led_blink_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predicted led bank state
   // ------------------------------------------------------------------
   logic [3:0]          led_flags     [NUM_LEDS];
   logic                led_by_time   [NUM_LEDS];
   logic [31:0]         led_remaining [NUM_LEDS];
   logic [7:0]          led_duty      [NUM_LEDS];
   logic [15:0]         led_period    [NUM_LEDS];
   logic [31:0]         led_next      [NUM_LEDS];
   logic [LEVELS_W-1:0] lamp_levels  = '0;
   logic [LEVELS_W-1:0] saved_lamps  = '0;
   logic [31:0]         clock_ms     = '0;

   initial begin
      for (int n = 0; n < NUM_LEDS; n++) begin
         led_flags[n]     = '0;
         led_by_time[n]   = 1'b0;
         led_remaining[n] = '0;
         led_duty[n]      = '0;
         led_period[n]    = '0;
         led_next[n]      = '0;
      end
   end

   // length of one phase in ms
   function automatic logic [31:0] phase_ms(input logic [7:0] pct, input logic [15:0] period);
      logic [31:0] product;
      product = {24'b0, pct} * {16'b0, period};
      return product / 32'd100;
   endfunction

   function automatic void start_blink(input logic [7:0] mask, input logic by_time,
                                       input logic [31:0] limit, input logic [7:0] pct,
                                       input logic [15:0] period);
      // degenerate duty or period forces the level, runs untouched
      if (mask == 0 || pct == 0 || period == 0) begin
         lamp_levels = lamp_levels & ~mask;
         return;
      end
      if (pct >= PCT_FULL) begin
         lamp_levels = lamp_levels | mask;
         return;
      end
      for (int n = 0; n < NUM_LEDS; n++) begin
         if (mask[n]) begin
            if (!led_flags[n][1])
               saved_lamps[n] = saved_lamps[n] | lamp_levels[n];
            led_flags[n]     = FLAG_RUN | ((limit == 0) ? FLAG_FOREVER : 4'b0);
            led_duty[n]      = pct;
            led_period[n]    = period;
            led_by_time[n]   = by_time;
            led_remaining[n] = limit;
            led_next[n]      = clock_ms;
         end
      end
   endfunction

   function automatic void start_toggle(input logic [7:0] mask, input logic [7:0] count,
                                        input logic [15:0] period);
      logic odd;
      logic lit;
      odd = count[0];
      if (mask == 0 || period == 0) begin
         lamp_levels = lamp_levels | mask;
         return;
      end
      for (int n = 0; n < NUM_LEDS; n++) begin
         if (mask[n]) begin
            lit = lamp_levels[n];
            if (!led_flags[n][1] && (lit != odd))
               saved_lamps[n] = 1'b1;
            led_flags[n]     = (lit ? FLAG_LIT : 4'b0) | FLAG_RUN |
                               ((count == 0) ? FLAG_FOREVER : 4'b0);
            led_duty[n]      = PCT_HALF;
            led_period[n]    = period;
            led_by_time[n]   = 1'b0;
            led_remaining[n] = ({24'b0, count} + 32'd1) / 32'd2;
            led_next[n]      = clock_ms;
            // a lit led with cycles left starts with its off phase
            if (lit) begin
               led_remaining[n] = led_remaining[n] - {31'b0, odd};
               if (led_remaining[n] != 0) begin
                  led_flags[n]   = led_flags[n] & ~FLAG_LIT;
                  lamp_levels[n] = 1'b0;
                  led_next[n]    = clock_ms + phase_ms(PCT_HALF, period);
               end
            end
         end
      end
   endfunction

   // one millisecond step of every running led
   function automatic void advance_clock();
      logic [7:0]  pct;
      logic [63:0] spent;
      logic        back;
      clock_ms = clock_ms + 32'd1;
      for (int n = 0; n < NUM_LEDS; n++) begin
         if (led_flags[n][1] && clock_ms >= led_next[n]) begin
            if (led_flags[n][0]) begin
               // end of on phase: charge the run
               pct = (led_duty[n] <= PCT_FULL) ? PCT_FULL - led_duty[n] : 8'd0;
               led_flags[n]   = led_flags[n] & ~FLAG_LIT;
               lamp_levels[n] = 1'b0;
               if (!led_flags[n][2]) begin
                  if (!led_by_time[n]) begin
                     if (led_remaining[n] == 0)
                        led_flags[n] = led_flags[n] & ~FLAG_RUN;
                     else begin
                        led_remaining[n] = led_remaining[n] - 32'd1;
                        if (led_remaining[n] == 0)
                           led_flags[n] = led_flags[n] & ~FLAG_RUN;
                     end
                  end else begin
                     spent = {32'b0, clock_ms - led_next[n]} + {48'b0, led_period[n]};
                     if ({32'b0, led_remaining[n]} > spent)
                        led_remaining[n] = led_remaining[n] - spent[31:0];
                     else begin
                        led_remaining[n] = '0;
                        led_flags[n]     = led_flags[n] & ~FLAG_RUN;
                     end
                  end
               end
            end else begin
               pct            = led_duty[n];
               led_flags[n]   = led_flags[n] | FLAG_LIT;
               lamp_levels[n] = 1'b1;
            end
            // schedule the next change, or restore the pre-run level
            if (led_flags[n][1])
               led_next[n] = clock_ms + phase_ms(pct, led_period[n]);
            else begin
               back           = saved_lamps[n];
               led_flags[n]   = back ? FLAG_LIT : 4'b0;
               lamp_levels[n] = back;
               saved_lamps[n] = 1'b0;
            end
         end
      end
   endfunction

   function automatic rsp_type predict_leds(input req_type item);
      rsp_type outcome;
      if (item.operation == OP_TICK)
         advance_clock();
      else if (int'(item.led_mask) < (1 << NUM_LEDS)) begin
         case (item.operation)
            OP_ON, OP_OFF, OP_TOGGLE: begin
               for (int n = 0; n < NUM_LEDS; n++) begin
                  if (item.led_mask[n]) begin
                     if (item.operation == OP_TOGGLE)
                        led_flags[n] = led_flags[n] ^ FLAG_LIT;
                     else
                        led_flags[n] = (item.operation == OP_ON) ? FLAG_LIT : 4'b0;
                     lamp_levels[n] = (led_flags[n] != 0);
                  end
               end
            end
            OP_BLINK_COUNT:
               start_blink(item.led_mask, 1'b0, {24'b0, item.cycle_count},
                           item.on_percent, item.blink_period);
            OP_BLINK_TIME:
               start_blink(item.led_mask, 1'b1, item.run_time,
                           item.on_percent, item.blink_period);
            OP_TOGGLE_RUN:
               start_toggle(item.led_mask, item.cycle_count, item.blink_period);
            default: ;
         endcase
      end
      outcome.led_levels = lamp_levels;
      for (int n = 0; n < NUM_LEDS; n++)
         outcome.blinking[n] = led_flags[n][1];
      return outcome;
   endfunction

   // ------------------------------------------------------------------
   // result checking and watchdog
   // ------------------------------------------------------------------
   rsp_type pending_levels [$];
   rsp_type wanted;
   int      error_count   = 0;
   int      items_seen    = 0;
   int      ticks_seen    = 0;
   int      results_seen  = 0;
   int      idle_cycles   = 0;

   always @(posedge clock) begin
      if (!reset) begin
         // compare the result transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_levels.size() == 0) begin
               $error("result with no pending transaction: %h", rsp_data);
               error_count++;
            end else begin
               wanted = pending_levels.pop_front();
               if (rsp_data.led_levels !== wanted.led_levels) begin
                  $error("led_levels mismatch: expected %h, actual %h",
                         wanted.led_levels, rsp_data.led_levels);
                  error_count++;
               end
               if (rsp_data.blinking !== wanted.blinking) begin
                  $error("blinking mismatch: expected %h, actual %h",
                         wanted.blinking, rsp_data.blinking);
                  error_count++;
               end
            end
         end
         // predict on every accepted request transaction
         if (req_valid && !req_stall) begin
            items_seen++;
            if (req_data.operation == OP_TICK)
               ticks_seen++;
            pending_levels.push_back(predict_leds(req_data));
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic req_type make_item(input logic [OP_W-1:0] op, input logic [7:0] mask,
                                         input logic [7:0] count, input logic [31:0] run,
                                         input logic [7:0] pct, input logic [15:0] period);
      req_type item;
      item.operation    = op;
      item.led_mask     = mask;
      item.cycle_count  = count;
      item.run_time     = run;
      item.on_percent   = pct;
      item.blink_period = period;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_levels.size() != 0)
         @(posedge clock);
   endtask

   // mostly ticks and short runs so that runs finish and restore
   function automatic req_type random_item();
      req_type item;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 55)      item.operation = OP_TICK;
      else if (pick < 62) item.operation = OP_ON;
      else if (pick < 69) item.operation = OP_OFF;
      else if (pick < 76) item.operation = OP_TOGGLE;
      else if (pick < 85) item.operation = OP_BLINK_COUNT;
      else if (pick < 93) item.operation = OP_BLINK_TIME;
      else if (pick < 98) item.operation = OP_TOGGLE_RUN;
      else                item.operation = OP_RESERVED;
      case ($urandom_range(9))
         0:       item.led_mask = 8'h00;
         1:       item.led_mask = 8'hFF;
         2, 3:    item.led_mask = 8'h01 << $urandom_range(7);
         default: item.led_mask = $urandom_range(255);
      endcase
      item.cycle_count = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8);
      case ($urandom_range(19))
         0:       item.run_time = $urandom;
         1:       item.run_time = '0;
         default: item.run_time = $urandom_range(80, 1);
      endcase
      case ($urandom_range(19))
         0:       item.on_percent = 8'd0;
         1:       item.on_percent = PCT_FULL;
         2:       item.on_percent = $urandom_range(255);
         default: item.on_percent = $urandom_range(99, 1);
      endcase
      case ($urandom_range(19))
         0:       item.blink_period = '0;
         1:       item.blink_period = $urandom_range(65535);
         default: item.blink_period = $urandom_range(12, 1);
      endcase
      return item;
   endfunction

   // forced levels and plain toggles
   task automatic test_level_commands();
      send_item(make_item(OP_ON,     8'hFF, 8'h00, 32'h0, 8'h00, 16'h0000));
      send_item(make_item(OP_OFF,    8'hFF, 8'hFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF));
      send_item(make_item(OP_TOGGLE, 8'h55, 8'h00, 32'h0, 8'h00, 16'h0000));
      send_item(make_item(OP_TOGGLE, 8'hFF, 8'h00, 32'h0, 8'h00, 16'h0000));
      // empty mask has no effect
      send_item(make_item(OP_ON,     8'h00, 8'h00, 32'h0, 8'h00, 16'h0000));
   endtask

   // count, duration and toggle runs stepped by ticks
   task automatic test_blink_runs();
      send_item(make_item(OP_BLINK_COUNT, 8'h01, 8'd2, 32'h0, 8'd50, 16'd4));
      send_item(make_item(OP_BLINK_TIME,  8'h02, 8'd0, 32'd9, 8'd30, 16'd5));
      send_item(make_item(OP_TOGGLE_RUN,  8'h0C, 8'd3, 32'h0, 8'd0,  16'd4));
      for (int i = 0; i < 6; i++)
         send_item(make_item(OP_TICK, 8'h00, 8'h00, 32'h0, 8'h00, 16'h0000));
   endtask

   task automatic test_corner_cases();
      // toggle while blinking, then restart a run on a blinking led
      send_item(make_item(OP_TOGGLE,      8'h01, 8'd0, 32'h0, 8'd0,  16'd0));
      send_item(make_item(OP_BLINK_COUNT, 8'h01, 8'd1, 32'h0, 8'd99, 16'd3));
      // zero percent, zero period, full and over-full percent
      send_item(make_item(OP_BLINK_COUNT, 8'hF0, 8'd5, 32'h0, 8'd0,   16'd10));
      send_item(make_item(OP_BLINK_TIME,  8'h0F, 8'd0, 32'd7, 8'd40,  16'd0));
      send_item(make_item(OP_BLINK_COUNT, 8'h30, 8'd2, 32'h0, PCT_FULL, 16'd6));
      send_item(make_item(OP_BLINK_COUNT, 8'hC0, 8'hFF, 32'h0, 8'hFF, 16'hFFFF));
      // toggle run with zero period lights the leds
      send_item(make_item(OP_TOGGLE_RUN,  8'h80, 8'd0, 32'h0, 8'd0,  16'd0));
      // zero-length phases make every on phase late
      send_item(make_item(OP_BLINK_TIME,  8'h10, 8'd0, 32'hFFFFFFFF, 8'd1, 16'd1));
      send_item(make_item(OP_RESERVED,    8'hFF, 8'hFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF));
      send_item(make_item(OP_TICK,        8'hFF, 8'hFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF));
      send_item(make_item(OP_OFF,         8'hFF, 8'd0, 32'h0, 8'd0,  16'd0));
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm <= (i >= 500 && i < 700);
         if (i != 0 && i % DRAIN_EVERY == 0)
            wait_for_results();
         send_item(random_item());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_level_commands();
      test_blink_runs();
      test_corner_cases();
      test_random_traffic();
      req_valid <= 1'b0;
      calm      <= 1'b0;
      @(posedge clock);
      while (pending_levels.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("summary: %0d transactions sent (%0d ticks, %0d commands), %0d results checked",
               items_seen, ticks_seen, items_seen - ticks_seen, results_seen);
      $display("summary: clock reached %0d ms, %0d mismatches", clock_ms, error_count);
      if (error_count == 0 && pending_levels.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

### files.f
rtl/core/mlbc_pkg.sv
rtl/core/mlbc_mem.sv
rtl/core/mlbc_div100.sv
rtl/core/mlbc_seq.sv
rtl/core/multi_led_blink_controller_top.sv
dv/multi_led_blink_controller_tb.sv
